[hdl/fids_pkg.sv]
// package for the floor indicator display scanner: symbol codes, types and segment table
package fids_pkg;

    // symbol index into the segment table
    typedef logic [4:0] sym_t;

    localparam sym_t SYM_ZERO  = 5'd0;
    localparam sym_t SYM_S     = 5'd5;
    localparam sym_t SYM_B     = 5'd11;
    localparam sym_t SYM_P     = 5'd22;
    localparam sym_t SYM_MINUS = 5'd25;
    localparam sym_t SYM_BLANK = 5'd26;

    // motion codes
    localparam logic [2:0] MOTION_STOP   = 3'd0;
    localparam logic [2:0] MOTION_UP     = 3'd1;
    localparam logic [2:0] MOTION_DOWN   = 3'd2;
    localparam logic [2:0] MOTION_RETURN = 3'd3;

    // register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_COMMON_ANODE = 3'd0;

    // symbols formed for one refresh request
    typedef struct packed {
        sym_t units;
        sym_t tens;
        sym_t top;
    } sym_set_t;

    // segment pattern a..g in bits 0..6, point in bit 7, active high
    function automatic logic [7:0] seg_pattern(input sym_t sym);
        logic [7:0] pat;
        unique case (sym)
            5'd0:  pat = 8'h3F;
            5'd1:  pat = 8'h06;
            5'd2:  pat = 8'h5B;
            5'd3:  pat = 8'h4F;
            5'd4:  pat = 8'h66;
            5'd5:  pat = 8'h6D;
            5'd6:  pat = 8'h7D;
            5'd7:  pat = 8'h07;
            5'd8:  pat = 8'h7F;
            5'd9:  pat = 8'h6F;
            5'd10: pat = 8'h5F;
            5'd11: pat = 8'h7C;
            5'd12: pat = 8'h58;
            5'd13: pat = 8'h5E;
            5'd14: pat = 8'h7B;
            5'd15: pat = 8'h71;
            5'd16: pat = 8'h77;
            5'd17: pat = 8'h39;
            5'd18: pat = 8'h79;
            5'd19: pat = 8'h76;
            5'd20: pat = 8'h1E;
            5'd21: pat = 8'h38;
            5'd22: pat = 8'h73;
            5'd23: pat = 8'h3E;
            5'd24: pat = 8'h80;
            5'd25: pat = 8'h40;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

[hdl/fids_symbol.sv]
// symbol former: floor and motion to units, tens and top symbols
module fids_symbol (
    input  logic signed [7:0]    floor,
    input  logic [2:0]           motion,
    input  fids_pkg::sym_t       dir_cur,
    output fids_pkg::sym_set_t   syms
);

    logic        neg;
    logic        is_zero;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [4:0]  quot;
    logic [7:0]  units_full;
    logic [4:0]  tens_digit;

    assign neg     = floor[7];
    assign is_zero = (floor == 8'sd0);
    // two's complement negate; -128 wraps to 128 which is the wanted magnitude
    assign mag     = neg ? (8'd0 - floor) : floor;

    // divide by ten through reciprocal, exact for every 8-bit magnitude (0 to 255)
    assign prod       = 16'(mag) * 16'd205;
    assign quot       = prod[15:11];
    assign units_full = mag - (8'(quot) * 8'd10);
    assign tens_digit = (quot >= 5'd10) ? (quot - 5'd10) : quot;

    always_comb begin
        syms.top = dir_cur;
        if (is_zero) begin
            syms.units = fids_pkg::SYM_B;
            syms.tens  = fids_pkg::SYM_P;
            priority if (motion == fids_pkg::MOTION_UP) begin
                syms.top = fids_pkg::SYM_S;
            end else if (motion == fids_pkg::MOTION_DOWN) begin
                syms.top = fids_pkg::SYM_B;
            end else begin
                syms.top = fids_pkg::SYM_BLANK;
            end
        end else begin
            syms.units = fids_pkg::sym_t'(units_full[3:0]);
            if (neg) begin
                syms.tens = fids_pkg::SYM_MINUS;
            end else if (tens_digit == 5'd0) begin
                syms.tens = fids_pkg::SYM_BLANK;
            end else begin
                syms.tens = tens_digit;
            end
            priority if (motion == fids_pkg::MOTION_RETURN) begin
                syms.top = neg ? fids_pkg::SYM_S : fids_pkg::SYM_B;
            end else if (motion == fids_pkg::MOTION_STOP) begin
                syms.top = fids_pkg::SYM_BLANK;
            end else if (motion == fids_pkg::MOTION_UP) begin
                syms.top = fids_pkg::SYM_S;
            end else if (motion == fids_pkg::MOTION_DOWN) begin
                syms.top = fids_pkg::SYM_B;
            end else begin
                syms.top = dir_cur;
            end
        end
    end

endmodule

[hdl/fids_regs.sv]
// configuration register block with apb-style access
module fids_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fids_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic                          common_anode
);

    logic ca_reg;
    logic ca_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[fids_pkg::PADDR_W-1:2] == fids_pkg::ADDR_COMMON_ANODE[fids_pkg::PADDR_W-1:2]);

    assign ca_next = wr_en ? pwdata[0] : ca_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ca_reg <= 1'b1;
        end else begin
            ca_reg <= ca_next;
        end
    end

    assign prdata = (paddr[fids_pkg::PADDR_W-1:2]
                     == fids_pkg::ADDR_COMMON_ANODE[fids_pkg::PADDR_W-1:2])
                    ? {31'd0, ca_reg} : 32'd0;
    assign common_anode = ca_reg;

endmodule

[hdl/floor_indicator_display_scanner_core.sv]
// top level of the floor indicator display scanner
// pipeline: input register, then result register; either can hold a request under back-pressure
// throughput: one refresh request per cycle while m_axis_tready stays high, limited by the input and result registers
// reset: synchronous active-low aresetn clears scan position to units digit,
// top symbol to "0", sets common_anode to 1 and empties both stages
module floor_indicator_display_scanner_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // refresh requests
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [7:0] floor, [10:8] motion, rest zero
    // display drive
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [3:0] digit_enable, [11:4] segments
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fids_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic signed [7:0] floor_reg;
    logic [2:0]        motion_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [3:0]        digit_enable_reg;
    logic [3:0]        digit_enable_next;
    logic [7:0]        segments_reg;
    logic [7:0]        segments_next;

    // scanner state
    logic [1:0]        scan_reg;
    logic [1:0]        scan_next;
    fids_pkg::sym_t    dir_reg;
    fids_pkg::sym_t    dir_next;

    logic              common_anode;
    logic              s_accept;
    logic              out_free;
    logic              advance;
    fids_pkg::sym_set_t syms;
    fids_pkg::sym_t    sym_sel;

    // result register frees up when empty or being taken this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    fids_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .common_anode (common_anode)
    );

    fids_symbol u_symbol (
        .floor   (floor_reg),
        .motion  (motion_reg),
        .dir_cur (dir_reg),
        .syms    (syms)
    );

    // pick the symbol for the digit being lit, hundreds always blank
    always_comb begin
        unique case (scan_reg)
            2'd0:    sym_sel = syms.units;
            2'd1:    sym_sel = syms.tens;
            2'd2:    sym_sel = fids_pkg::SYM_BLANK;
            default: sym_sel = syms.top;
        endcase
    end

    // polarity flip for common anode, digit select stays active low
    assign segments_next     = fids_pkg::seg_pattern(sym_sel) ^ {8{common_anode}};
    assign digit_enable_next = ~(4'd1 << scan_reg);

    // state moves only when a request passes into the result register
    assign scan_next      = advance ? (scan_reg + 2'd1) : scan_reg;
    assign dir_next       = advance ? syms.top : dir_reg;
    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= 2'd0;
            dir_reg       <= fids_pkg::SYM_ZERO;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            scan_reg      <= scan_next;
            dir_reg       <= dir_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            floor_reg  <= s_axis_tdata[7:0];
            motion_reg <= s_axis_tdata[10:8];
        end
        if (advance) begin
            digit_enable_reg <= digit_enable_next;
            segments_reg     <= segments_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, segments_reg, digit_enable_reg};

    // exactly one digit lit on every result
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $onehot(~m_axis_tdata[3:0]))
        else $error("digit select not one-hot active low");

    // scan position steps by one per request passed on
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (scan_reg == $past(scan_reg) + 2'd1))
        else $error("scan position did not advance");

    // scanner state holds while no request passes on
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(scan_reg) && $stable(dir_reg)))
        else $error("scanner state changed without a request");

    // a request waiting in the input stage leaves it when the result frees up and no new request is accepted
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free && !s_accept) |=> !in_valid_reg)
        else $error("input stage did not drain");

endmodule
